// ===== rtl/isps_pkg.sv =====
// Shared types and constants of the isolated pixel smoothing filter.
// No dependencies; compile first.
package isps_pkg;

   // Configuration register port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTLIER_THRESHOLD = 2'd2;

   // Register widths and reset values
   localparam int WIDTH_REG_W  = 6;
   localparam int HEIGHT_REG_W = 10;
   localparam int THRESH_W     = 8;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 6'd32;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 10'd20;
   localparam logic [THRESH_W-1:0]     THRESH_RESET = 8'd1;

   // Smallest frame dimension in use
   localparam logic [WIDTH_REG_W-1:0]  MIN_WIDTH  = 6'd2;
   localparam logic [HEIGHT_REG_W-1:0] MIN_HEIGHT = 10'd2;

   // Neighbour count codes
   localparam int CNT_W = 3;
   localparam logic [CNT_W-1:0] CNT_TWO   = 3'd2;
   localparam logic [CNT_W-1:0] CNT_THREE = 3'd3;

   // Which of the four neighbours exist for one pixel
   typedef struct packed {
      logic up;
      logic left;
      logic right;
      logic down;
   } nb_mask_type;

endpackage

// ===== rtl/isps_if.sv =====
// Valid/ready stream channels of the isolated pixel smoothing filter.
// No dependencies; compile after isps_pkg.
interface isps_req_if #(
   parameter int PIXEL_BITS = 8
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

interface isps_rsp_if #(
   parameter int PIXEL_BITS = 8
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_out;
   logic                  replaced;
   logic                  frame_last;

   modport source (output valid, output pixel_out, output replaced, output frame_last,
                   input ready);
   modport sink   (input valid, input pixel_out, input replaced, input frame_last,
                   output ready);
endinterface

// ===== rtl/isps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module isps_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/isolated_pixel_smoothing_filter.sv =====
// Top level of the isolated pixel smoothing filter.
// Uses isps_pkg, the channels in isps_if and three isps_ram line stores.
//
// Pixels enter in raster order, one per clock unless held off, and leave
// filtered one row later: while row r streams in, the beat for column c
// releases the result for row r-1, column c, and the last beat of a frame
// releases the whole final row. A pixel that differs by more than
// outlier_threshold from every neighbour that exists (up, down, left, right)
// is replaced by their mean, rounded half up. The sustained rate is one pixel
// per clock while the result side does not stall; after the last pixel of a
// frame the input is held off while the final row is read back from the line
// stores over their read ports, one column per cycle while the result side
// does not stall. A pixel passes five register stages (line store read,
// compare and sum, divide multiply, mean select, output register). Every line
// store entry is written within a frame before a value read from it is used,
// so the stores need no clearing after reset. Write configuration only while
// the block is idle; changing image_width or image_height restarts the frame.
module isolated_pixel_smoothing_filter #(
   parameter int MAX_WIDTH  = 32,
   parameter int PIXEL_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   isps_req_if.sink                           req_chan,
   isps_rsp_if.source                         rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [isps_pkg::CSR_INDEX_W-1:0]   csr_wr_index,
   input  logic [isps_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   localparam int AW     = $clog2(MAX_WIDTH);
   localparam int CW     = isps_pkg::WIDTH_REG_W + 1;
   localparam int SUM_W  = PIXEL_BITS + 2;
   localparam int SUMX_W = SUM_W + 1;
   localparam int NUM_W  = PIXEL_BITS + 3;
   localparam int RCP_W  = NUM_W + 1;
   localparam int PROD_W = NUM_W + RCP_W;
   localparam int CMP_W  = (PIXEL_BITS > isps_pkg::THRESH_W) ? PIXEL_BITS
                                                             : isps_pkg::THRESH_W;
   // floor(n / 3) = (n * RECIP3) >> RCP_W for every n below 2**NUM_W
   localparam logic [RCP_W-1:0] RECIP3 =
      RCP_W'(((64'd1 << RCP_W) + 64'd2) / 64'd3);
   localparam logic [isps_pkg::WIDTH_REG_W-1:0] W_MAX =
      isps_pkg::WIDTH_REG_W'(MAX_WIDTH);

   function automatic logic [PIXEL_BITS-1:0] abs_diff(input logic [PIXEL_BITS-1:0] a,
                                                      input logic [PIXEL_BITS-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // ---------------------------------------------------------------- registers
   logic [isps_pkg::WIDTH_REG_W-1:0]  width_reg_ff;
   logic [isps_pkg::HEIGHT_REG_W-1:0] height_reg_ff;
   logic [isps_pkg::THRESH_W-1:0]     thresh_ff;

   logic [isps_pkg::WIDTH_REG_W-1:0]  w_eff;
   logic [isps_pkg::HEIGHT_REG_W-1:0] h_eff;

   logic [AW-1:0]                     col_ff, col_in;
   logic [isps_pkg::HEIGHT_REG_W-1:0] row_ff, row_in;
   logic                              flush_on_ff, flush_on_in;
   logic [AW-1:0]                     flush_x_ff, flush_x_in;

   // Stage 0: line store read
   logic                        s0_valid_ff;
   logic                        s0_emit_ff;
   logic                        s0_write_ff;
   logic [AW-1:0]               s0_col_ff;
   logic [PIXEL_BITS-1:0]       s0_pix_ff;
   isps_pkg::nb_mask_type       s0_mask_ff;
   logic                        s0_last_ff;
   logic                        s0_right_byp_ff;
   logic [PIXEL_BITS-1:0]       s0_right_pix_ff;
   logic [PIXEL_BITS-1:0]       left_ff;

   // Stage 1: compare and sum
   logic                        s1_valid_ff;
   logic [PIXEL_BITS-1:0]       s1_centre_ff, s1_up_ff, s1_left_ff, s1_right_ff, s1_down_ff;
   isps_pkg::nb_mask_type       s1_mask_ff;
   logic                        s1_last_ff;

   // Stage 2: divide multiply
   logic                        s2_valid_ff;
   logic [PIXEL_BITS-1:0]       s2_centre_ff;
   logic                        s2_outlier_ff;
   logic [SUM_W-1:0]            s2_sum_ff;
   logic [isps_pkg::CNT_W-1:0]  s2_cnt_ff;
   logic                        s2_last_ff;

   // Stage 3: mean select
   logic                        s3_valid_ff;
   logic [PROD_W-1:0]           s3_prod_ff;
   logic [PIXEL_BITS-1:0]       s3_mean2_ff, s3_mean4_ff, s3_centre_ff;
   logic [isps_pkg::CNT_W-1:0]  s3_cnt_ff;
   logic                        s3_outlier_ff;
   logic                        s3_last_ff;

   // Output register
   logic                        out_valid_ff;
   logic [PIXEL_BITS-1:0]       out_pix_ff;
   logic                        out_rep_ff;
   logic                        out_last_ff;

   // ------------------------------------------------------------ flow control
   logic out_ready, s3_ready, s2_ready, s1_ready;
   logic s0_adv, s0_load_ok, s0_load;
   logic in_acc, flush_issue;

   assign out_ready  = !out_valid_ff || rsp_chan.ready;
   assign s3_ready   = !s3_valid_ff || out_ready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign s0_adv     = s0_valid_ff && (!s0_emit_ff || s1_ready);
   assign s0_load_ok = !s0_valid_ff || s0_adv;

   assign req_chan.ready = !flush_on_ff && s0_load_ok;
   assign in_acc         = req_chan.valid && req_chan.ready;
   // First flush column waits until the last pixel has been written back
   assign flush_issue    = flush_on_ff &&
                           ((flush_x_ff == '0) ? !s0_valid_ff : s0_load_ok);
   assign s0_load        = in_acc || flush_issue;

   // ----------------------------------------------------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         width_reg_ff  <= isps_pkg::WIDTH_RESET;
         height_reg_ff <= isps_pkg::HEIGHT_RESET;
         thresh_ff     <= isps_pkg::THRESH_RESET;
      end else if (csr_wr_en) begin
         case (csr_wr_index)
            isps_pkg::CSR_IMAGE_WIDTH: begin
               width_reg_ff <= csr_wr_data[isps_pkg::WIDTH_REG_W-1:0];
            end
            isps_pkg::CSR_IMAGE_HEIGHT: begin
               height_reg_ff <= csr_wr_data[isps_pkg::HEIGHT_REG_W-1:0];
            end
            isps_pkg::CSR_OUTLIER_THRESHOLD: begin
               thresh_ff <= csr_wr_data[isps_pkg::THRESH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Clamp the frame size to the usable range
   always_comb begin
      if (width_reg_ff < isps_pkg::MIN_WIDTH) begin
         w_eff = isps_pkg::MIN_WIDTH;
      end else if (width_reg_ff > W_MAX) begin
         w_eff = W_MAX;
      end else begin
         w_eff = width_reg_ff;
      end
      h_eff = (height_reg_ff < isps_pkg::MIN_HEIGHT) ? isps_pkg::MIN_HEIGHT
                                                     : height_reg_ff;
   end

   // ------------------------------------------------------- source selection
   logic [AW-1:0] src_col;
   logic [CW-1:0] src_col_plus;
   logic          src_has_right;
   logic [AW-1:0] rd_addr_right;
   logic          last_row;
   isps_pkg::nb_mask_type src_mask;

   always_comb begin
      src_col       = flush_on_ff ? flush_x_ff : col_ff;
      src_col_plus  = CW'(src_col) + CW'(1);
      src_has_right = src_col_plus < CW'(w_eff);
      rd_addr_right = src_has_right ? src_col_plus[AW-1:0] : src_col;
      last_row      = row_ff >= (h_eff - isps_pkg::HEIGHT_REG_W'(1));
      src_mask.up    = flush_on_ff || (row_ff > isps_pkg::HEIGHT_REG_W'(1));
      src_mask.left  = src_col != '0;
      src_mask.right = src_has_right;
      src_mask.down  = !flush_on_ff;
   end

   // ------------------------------------------------ frame position and flush
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      flush_on_in = flush_on_ff;
      flush_x_in  = flush_x_ff;
      if (csr_wr_en && (csr_wr_index == isps_pkg::CSR_IMAGE_WIDTH ||
                        csr_wr_index == isps_pkg::CSR_IMAGE_HEIGHT)) begin
         col_in = '0;
         row_in = '0;
      end else if (in_acc) begin
         if (!src_has_right && last_row) begin
            col_in      = '0;
            row_in      = '0;
            flush_on_in = 1'b1;
            flush_x_in  = '0;
         end else if (!src_has_right) begin
            col_in = '0;
            row_in = row_ff + isps_pkg::HEIGHT_REG_W'(1);
         end else begin
            col_in = src_col_plus[AW-1:0];
         end
      end else if (flush_issue) begin
         if (!src_has_right) begin
            flush_on_in = 1'b0;
            flush_x_in  = '0;
         end else begin
            flush_x_in = src_col_plus[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         flush_on_ff <= 1'b0;
         flush_x_ff  <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         flush_on_ff <= flush_on_in;
         flush_x_ff  <= flush_x_in;
      end
   end

   // -------------------------------------------------------------- line stores
   // Newer row is kept twice so that column c and column c+1 read together
   logic [PIXEL_BITS-1:0] cur_rd, right_rd, up_rd;
   logic                  store_wr;

   assign store_wr = s0_adv && s0_write_ff;

   isps_ram #(.DATA_W(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_cur_row (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (s0_col_ff),
      .wr_data (s0_pix_ff),
      .rd_en   (s0_load),
      .rd_addr (src_col),
      .rd_data (cur_rd)
   );

   isps_ram #(.DATA_W(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_cur_row_right (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (s0_col_ff),
      .wr_data (s0_pix_ff),
      .rd_en   (s0_load),
      .rd_addr (rd_addr_right),
      .rd_data (right_rd)
   );

   isps_ram #(.DATA_W(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_prev_row (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (s0_col_ff),
      .wr_data (cur_rd),
      .rd_en   (s0_load),
      .rd_addr (src_col),
      .rd_data (up_rd)
   );

   // ------------------------------------------------------------------ stage 0
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_load_ok) begin
         s0_valid_ff <= s0_load;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_load) begin
         s0_emit_ff  <= flush_on_ff || (row_ff != '0);
         s0_write_ff <= !flush_on_ff;
         s0_col_ff   <= src_col;
         s0_pix_ff   <= req_chan.pixel_in;
         s0_mask_ff  <= src_mask;
         s0_last_ff  <= flush_on_ff && !src_has_right;
         // Right neighbour written back in the same cycle it is read
         // (two-column frames): take it from the beat being written
         s0_right_byp_ff <= store_wr && (s0_col_ff == rd_addr_right);
         s0_right_pix_ff <= s0_pix_ff;
      end
   end

   // Hold the centre of the previous column as the next left neighbour
   always_ff @(posedge clock) begin
      if (s0_adv) begin
         left_ff <= cur_rd;
      end
   end

   // ------------------------------------------------------------------ stage 1
   logic s1_in_valid;
   assign s1_in_valid = s0_adv && s0_emit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= s1_in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && s1_in_valid) begin
         s1_centre_ff <= cur_rd;
         s1_up_ff     <= up_rd;
         s1_left_ff   <= left_ff;
         s1_right_ff  <= s0_right_byp_ff ? s0_right_pix_ff : right_rd;
         s1_down_ff   <= s0_pix_ff;
         s1_mask_ff   <= s0_mask_ff;
         s1_last_ff   <= s0_last_ff;
      end
   end

   // Compare each existing neighbour and sum them
   logic                       close_up, close_left, close_right, close_down;
   logic                       s1_outlier;
   logic [SUM_W-1:0]           s1_sum;
   logic [isps_pkg::CNT_W-1:0] s1_cnt;

   always_comb begin
      close_up    = s1_mask_ff.up &&
                    (CMP_W'(abs_diff(s1_centre_ff, s1_up_ff)) <= CMP_W'(thresh_ff));
      close_left  = s1_mask_ff.left &&
                    (CMP_W'(abs_diff(s1_centre_ff, s1_left_ff)) <= CMP_W'(thresh_ff));
      close_right = s1_mask_ff.right &&
                    (CMP_W'(abs_diff(s1_centre_ff, s1_right_ff)) <= CMP_W'(thresh_ff));
      close_down  = s1_mask_ff.down &&
                    (CMP_W'(abs_diff(s1_centre_ff, s1_down_ff)) <= CMP_W'(thresh_ff));
      s1_outlier  = !(close_up || close_left || close_right || close_down);
      s1_sum = (s1_mask_ff.up    ? SUM_W'(s1_up_ff)    : '0) +
               (s1_mask_ff.left  ? SUM_W'(s1_left_ff)  : '0) +
               (s1_mask_ff.right ? SUM_W'(s1_right_ff) : '0) +
               (s1_mask_ff.down  ? SUM_W'(s1_down_ff)  : '0);
      s1_cnt = isps_pkg::CNT_W'(s1_mask_ff.up)    + isps_pkg::CNT_W'(s1_mask_ff.left) +
               isps_pkg::CNT_W'(s1_mask_ff.right) + isps_pkg::CNT_W'(s1_mask_ff.down);
   end

   // ------------------------------------------------------------------ stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_centre_ff  <= s1_centre_ff;
         s2_outlier_ff <= s1_outlier;
         s2_sum_ff     <= s1_sum;
         s2_cnt_ff     <= s1_cnt;
         s2_last_ff    <= s1_last_ff;
      end
   end

   // Means for two and four neighbours by shift, three by reciprocal multiply
   logic [NUM_W-1:0]      s2_num3;
   logic [PROD_W-1:0]     s2_prod;
   logic [SUMX_W-1:0]     s2_half_t, s2_quarter_t;

   always_comb begin
      s2_num3      = {s2_sum_ff, 1'b0} + NUM_W'(3);
      s2_prod      = PROD_W'(s2_num3) * PROD_W'(RECIP3);
      s2_half_t    = SUMX_W'(s2_sum_ff) + SUMX_W'(1);
      s2_quarter_t = SUMX_W'(s2_sum_ff) + SUMX_W'(2);
   end

   // ------------------------------------------------------------------ stage 3
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_prod_ff    <= s2_prod;
         s3_mean2_ff   <= s2_half_t[PIXEL_BITS:1];
         s3_mean4_ff   <= s2_quarter_t[PIXEL_BITS+1:2];
         s3_cnt_ff     <= s2_cnt_ff;
         s3_centre_ff  <= s2_centre_ff;
         s3_outlier_ff <= s2_outlier_ff;
         s3_last_ff    <= s2_last_ff;
      end
   end

   // Pick the mean for the neighbour count, keep the centre if not an outlier
   logic [PIXEL_BITS-1:0] s3_mean;
   logic [PIXEL_BITS-1:0] s3_value;

   always_comb begin
      case (s3_cnt_ff)
         isps_pkg::CNT_TWO:   s3_mean = s3_mean2_ff;
         isps_pkg::CNT_THREE: s3_mean = s3_prod_ff[RCP_W+1 +: PIXEL_BITS];
         default:             s3_mean = s3_mean4_ff;
      endcase
      s3_value = s3_outlier_ff ? s3_mean : s3_centre_ff;
   end

   // ----------------------------------------------------------- output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s3_valid_ff) begin
         out_pix_ff  <= s3_value;
         out_rep_ff  <= s3_outlier_ff;
         out_last_ff <= s3_last_ff;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.pixel_out  = out_pix_ff;
   assign rsp_chan.replaced   = out_rep_ff;
   assign rsp_chan.frame_last = out_last_ff;

endmodule
